[sv/cmac_pkg.sv]
// Shared types and constants for the move-and-add core.
package cmac_pkg;

  localparam int ADDR_BITS = 16;
  localparam int MEM_DEPTH = 1 << ADDR_BITS;

  localparam logic [2:0] CODE_M = 3'd6;
  localparam logic [2:0] CODE_A = 3'd7;

  localparam logic [7:0] OP_HLT  = 8'h76;
  localparam logic [7:0] OP_STAX_B = 8'h02;
  localparam logic [7:0] OP_STAX_D = 8'h12;
  localparam logic [7:0] OP_LDAX_B = 8'h0A;
  localparam logic [7:0] OP_LDAX_D = 8'h1A;
  localparam logic [7:0] OP_LXI_B = 8'h01;
  localparam logic [7:0] OP_LXI_D = 8'h11;
  localparam logic [7:0] OP_LXI_H = 8'h21;
  localparam logic [7:0] OP_LXI_SP = 8'h31;
  localparam logic [7:0] OP_STA  = 8'h32;
  localparam logic [7:0] OP_LDA  = 8'h3A;
  localparam logic [7:0] OP_XCHG = 8'hEB;
  localparam logic [7:0] OP_XTHL = 8'hE3;
  localparam logic [7:0] OP_ADI  = 8'hC6;
  localparam logic [7:0] OP_ACI  = 8'hCE;
  localparam logic [7:0] OP_SUI  = 8'hD6;
  localparam logic [7:0] OP_SBI  = 8'hDE;

  typedef enum logic [3:0] {
    K_BAD, K_MOV, K_MVI, K_ALU, K_ALUI, K_LXI, K_STAX, K_LDAX,
    K_STA, K_LDA, K_XCHG, K_XTHL
  } kind_t;

  // Decoded request handed from front to back.
  typedef struct packed {
    kind_t      kind;
    logic [2:0] dst;
    logic [2:0] src;
    logic [1:0] aluk;   // bit1: subtract, bit0: use carry
    logic [1:0] pair;   // 0 BC, 1 DE, 2 HL, 3 SP
    logic [7:0] lo;
    logic [7:0] hi;
  } instr_t;

endpackage

[sv/cmac_ram.sv]
// Generic single-port RAM with registered read.
module cmac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

[sv/cmac_front.sv]
// Front end: opcode decode and a two-entry request queue.
module cmac_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [7:0]        command,
  input  logic [7:0]        imm_low,
  input  logic [7:0]        imm_high,
  output logic              q_valid,
  output cmac_pkg::instr_t  q_item,
  input  logic              q_take
);

  cmac_pkg::instr_t dec;
  cmac_pkg::instr_t slot [2];
  logic       head;
  logic       tail;
  logic [1:0] count;
  logic       wr_en;
  logic       rd_en;

  always_comb begin
    dec.kind = cmac_pkg::K_BAD;
    dec.dst  = command[5:3];
    dec.src  = command[2:0];
    dec.aluk = command[4:3];
    dec.pair = command[5:4];
    dec.lo   = imm_low;
    dec.hi   = imm_high;
    if (command[7:6] == 2'b01 && command != cmac_pkg::OP_HLT) begin
      dec.kind = cmac_pkg::K_MOV;
    end else if (command[7:6] == 2'b00 && command[2:0] == 3'b110) begin
      dec.kind = cmac_pkg::K_MVI;
    end else if (command[7:5] == 3'b100) begin
      dec.kind = cmac_pkg::K_ALU;
    end else begin
      case (command)
        cmac_pkg::OP_LXI_B, cmac_pkg::OP_LXI_D,
        cmac_pkg::OP_LXI_H, cmac_pkg::OP_LXI_SP: dec.kind = cmac_pkg::K_LXI;
        cmac_pkg::OP_STAX_B, cmac_pkg::OP_STAX_D: dec.kind = cmac_pkg::K_STAX;
        cmac_pkg::OP_LDAX_B, cmac_pkg::OP_LDAX_D: dec.kind = cmac_pkg::K_LDAX;
        cmac_pkg::OP_STA:  dec.kind = cmac_pkg::K_STA;
        cmac_pkg::OP_LDA:  dec.kind = cmac_pkg::K_LDA;
        cmac_pkg::OP_XCHG: dec.kind = cmac_pkg::K_XCHG;
        cmac_pkg::OP_XTHL: dec.kind = cmac_pkg::K_XTHL;
        cmac_pkg::OP_ADI, cmac_pkg::OP_ACI,
        cmac_pkg::OP_SUI, cmac_pkg::OP_SBI: dec.kind = cmac_pkg::K_ALUI;
        default: dec.kind = cmac_pkg::K_BAD;
      endcase
    end
  end

  assign full    = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_item  = slot[head];
  assign wr_en   = push && !full;
  assign rd_en   = q_take && q_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot[tail] <= dec;
    end
    if (rst) begin
      head  <= 1'b0;
      tail  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr_en) tail <= ~tail;
      if (rd_en) head <= ~head;
      count <= count + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

endmodule

[sv/cmac_back.sv]
// Back end: register file, data memory sequencing, ALU and result register.
module cmac_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  cmac_pkg::instr_t q_item,
  output logic             q_take,
  input  logic             pop,
  output logic             empty,
  output logic [7:0]       acc_out,
  output logic [7:0]       b_out,
  output logic [7:0]       c_out,
  output logic [7:0]       d_out,
  output logic [7:0]       e_out,
  output logic [7:0]       h_out,
  output logic [7:0]       l_out,
  output logic [15:0]      sp_out,
  output logic             carry_out,
  output logic             bad_opcode
);

  typedef enum logic [2:0] {S_IDLE, S_RD, S_X0, S_X1, S_X2} state_t;
  localparam int AW = cmac_pkg::ADDR_BITS;

  state_t state, state_next;
  cmac_pkg::instr_t cur;
  logic [7:0] a, b, c, d, e, h, l;
  logic [7:0] a_next, b_next, c_next, d_next, e_next, h_next, l_next;
  logic [15:0] sp, sp_next;
  logic carry, carry_next;
  logic [7:0] t0;
  logic out_valid;
  logic done;
  logic bad;

  logic we, re;
  logic [AW-1:0] maddr;
  logic [7:0] wdata, rdata;

  cmac_pkg::instr_t ins;
  logic [7:0] opnd;
  logic [7:0] srcv;
  logic [8:0] sum9;
  logic [8:0] dif9;
  logic cin;
  logic out_free;
  logic needs_read;

  // full 16-bit addresses, cut to AW bits where they reach the RAM
  logic [15:0] hl_pair, bc_pair, de_pair, imm_pair, sp_inc;

  cmac_ram #(.WIDTH(8), .DEPTH(cmac_pkg::MEM_DEPTH)) u_ram (
    .clk(clk), .we(we), .re(re), .addr(maddr), .wdata(wdata), .rdata(rdata)
  );

  function automatic logic [7:0] reg_sel(input logic [2:0] code,
      input logic [7:0] ra, input logic [7:0] rb, input logic [7:0] rc,
      input logic [7:0] rd, input logic [7:0] re_, input logic [7:0] rh,
      input logic [7:0] rl);
    case (code)
      3'd0: reg_sel = rb;
      3'd1: reg_sel = rc;
      3'd2: reg_sel = rd;
      3'd3: reg_sel = re_;
      3'd4: reg_sel = rh;
      3'd5: reg_sel = rl;
      default: reg_sel = ra;
    endcase
  endfunction

  assign out_free = !out_valid || pop;
  assign ins      = (state == S_IDLE) ? q_item : cur;
  assign srcv     = reg_sel(ins.src, a, b, c, d, e, h, l);
  assign hl_pair  = {h, l};
  assign bc_pair  = {b, c};
  assign de_pair  = {d, e};
  assign imm_pair = {ins.hi, ins.lo};
  assign sp_inc   = sp + 16'd1;
  assign needs_read =
      ((ins.kind == cmac_pkg::K_MOV || ins.kind == cmac_pkg::K_ALU) &&
       ins.src == cmac_pkg::CODE_M) ||
      ins.kind == cmac_pkg::K_LDAX || ins.kind == cmac_pkg::K_LDA ||
      ins.kind == cmac_pkg::K_XTHL;

  always_comb begin
    state_next = state;
    a_next = a; b_next = b; c_next = c; d_next = d;
    e_next = e; h_next = h; l_next = l;
    sp_next = sp; carry_next = carry;
    we = 1'b0; re = 1'b0; wdata = a;
    maddr = hl_pair[AW-1:0];
    done = 1'b0; bad = 1'b0; q_take = 1'b0;
    opnd = (ins.src == cmac_pkg::CODE_M) ? rdata : srcv;
    if (ins.kind == cmac_pkg::K_ALUI) opnd = ins.lo;
    if (ins.kind == cmac_pkg::K_MVI) opnd = ins.lo;
    cin  = ins.aluk[0] & carry;
    sum9 = {1'b0, a} + {1'b0, opnd} + {8'd0, cin};
    dif9 = {1'b0, a} - {1'b0, opnd} - {8'd0, cin};

    // memory address for this request
    case (ins.kind)
      cmac_pkg::K_STAX, cmac_pkg::K_LDAX:
        maddr = ins.pair[0] ? de_pair[AW-1:0] : bc_pair[AW-1:0];
      cmac_pkg::K_STA, cmac_pkg::K_LDA: maddr = imm_pair[AW-1:0];
      cmac_pkg::K_XTHL:
        maddr = (state == S_X1 || state == S_X2) ? sp_inc[AW-1:0] : sp[AW-1:0];
      default: maddr = hl_pair[AW-1:0];
    endcase

    case (state)
      S_IDLE: begin
        if (q_valid && out_free) begin
          q_take = 1'b1;
          if (needs_read) begin
            re = 1'b1;
            state_next = (ins.kind == cmac_pkg::K_XTHL) ? S_X0 : S_RD;
          end else begin
            done = 1'b1;
          end
        end
      end
      S_RD: done = 1'b1;
      S_X0: begin
        we = 1'b1; wdata = l;
        state_next = S_X1;
      end
      S_X1: begin
        re = 1'b1;
        state_next = S_X2;
      end
      S_X2: begin
        we = 1'b1; wdata = h;
        l_next = t0; h_next = rdata;
        done = 1'b1;
      end
      default: state_next = S_IDLE;
    endcase

    if (done) begin
      if (state != S_IDLE) state_next = S_IDLE;
      case (ins.kind)
        cmac_pkg::K_MOV, cmac_pkg::K_MVI: begin
          if (ins.dst == cmac_pkg::CODE_M) begin
            we = 1'b1; wdata = opnd;
          end else begin
            case (ins.dst)
              3'd0: b_next = opnd;
              3'd1: c_next = opnd;
              3'd2: d_next = opnd;
              3'd3: e_next = opnd;
              3'd4: h_next = opnd;
              3'd5: l_next = opnd;
              default: a_next = opnd;
            endcase
          end
        end
        cmac_pkg::K_ALU, cmac_pkg::K_ALUI: begin
          if (ins.aluk[1]) begin
            a_next = dif9[7:0]; carry_next = dif9[8];
          end else begin
            a_next = sum9[7:0]; carry_next = sum9[8];
          end
        end
        cmac_pkg::K_LXI: begin
          case (ins.pair)
            2'd0: begin b_next = ins.hi; c_next = ins.lo; end
            2'd1: begin d_next = ins.hi; e_next = ins.lo; end
            2'd2: begin h_next = ins.hi; l_next = ins.lo; end
            default: sp_next = {ins.hi, ins.lo};
          endcase
        end
        cmac_pkg::K_STAX, cmac_pkg::K_STA: begin
          we = 1'b1; wdata = a;
        end
        cmac_pkg::K_LDAX, cmac_pkg::K_LDA: a_next = rdata;
        cmac_pkg::K_XCHG: begin
          d_next = h; e_next = l; h_next = d; l_next = e;
        end
        cmac_pkg::K_XTHL: ;
        default: bad = 1'b1;
      endcase
    end
  end

  assign empty = !out_valid;

  always_ff @(posedge clk) begin
    if (state == S_IDLE) cur <= q_item;
    if (state == S_X0) t0 <= rdata;
    if (done) begin
      acc_out <= a_next; b_out <= b_next; c_out <= c_next; d_out <= d_next;
      e_out <= e_next; h_out <= h_next; l_out <= l_next; sp_out <= sp_next;
      carry_out <= carry_next; bad_opcode <= bad;
    end
    if (rst) begin
      state <= S_IDLE;
      a <= '0; b <= '0; c <= '0; d <= '0; e <= '0; h <= '0; l <= '0;
      sp <= '0; carry <= 1'b0; out_valid <= 1'b0;
    end else begin
      state <= state_next;
      a <= a_next; b <= b_next; c <= c_next; d <= d_next;
      e <= e_next; h <= h_next; l <= l_next;
      sp <= sp_next; carry <= carry_next;
      if (done) out_valid <= 1'b1;
      else if (pop) out_valid <= 1'b0;
    end
  end

  a_no_result_midflight: assert property (@(posedge clk) disable iff (rst)
      (state != S_IDLE) |-> !out_valid)
    else $error("result pending while a request is in flight");
  a_one_mem_access: assert property (@(posedge clk) disable iff (rst)
      !(we && re))
    else $error("memory read and write in one cycle");
  a_xthl_seq: assert property (@(posedge clk) disable iff (rst)
      (state == S_X0) |=> (state == S_X1))
    else $error("XTHL sequence broken");
  a_done_needs_room: assert property (@(posedge clk) disable iff (rst)
      done |-> (!out_valid || pop))
    else $error("result overwrote an untaken result");

endmodule

[sv/cpu_move_and_add_core.sv]
// Top level of the move-and-add core: front decode queue plus back end.
// One request is one 8080-style instruction (opcode plus up to two immediate
// bytes); one result with the whole register state comes back for each. The
// front end decodes opcodes into a two-entry queue; the back end runs them
// against the registers and a 2^ADDR_BITS byte memory with a single port and
// registered read. Register-only instructions and memory stores finish in the
// cycle they are taken, so such requests stream at one per cycle while the
// results are popped. Instructions that read memory (MOV r,M, ALU M, LDAX,
// LDA) wait in S_RD for the registered memory read; XTHL steps through read,
// write, read, write on the one port. Results sit in an output register; a
// new request can start in the cycle the previous result is popped. Unknown
// opcodes set bad_opcode and change nothing. Memory is not cleared at reset:
// reading a byte that was never written gives an undefined value.
module cpu_move_and_add_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  command,
  input  logic [7:0]  imm_low,
  input  logic [7:0]  imm_high,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  acc_out,
  output logic [7:0]  b_out,
  output logic [7:0]  c_out,
  output logic [7:0]  d_out,
  output logic [7:0]  e_out,
  output logic [7:0]  h_out,
  output logic [7:0]  l_out,
  output logic [15:0] sp_out,
  output logic        carry_out,
  output logic        bad_opcode
);

  logic             q_valid;
  logic             q_take;
  cmac_pkg::instr_t q_item;

  cmac_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .command(command), .imm_low(imm_low), .imm_high(imm_high),
    .q_valid(q_valid), .q_item(q_item), .q_take(q_take)
  );

  cmac_back u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_item(q_item), .q_take(q_take),
    .pop(pop), .empty(empty), .acc_out(acc_out), .b_out(b_out), .c_out(c_out),
    .d_out(d_out), .e_out(e_out), .h_out(h_out), .l_out(l_out),
    .sp_out(sp_out), .carry_out(carry_out), .bad_opcode(bad_opcode)
  );

endmodule
